FILE: design/eipp_pkg.sv
// shared types and constants for the ethernet/ipv4/l4 header parser
// no dependencies
`timescale 1ns / 1ps

package eipp_pkg;

    localparam int PositionWidthDefault = 16;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [2:0] KIND_NOT_IP    = 3'd0;
    localparam logic [2:0] KIND_IP_OTHER  = 3'd1;
    localparam logic [2:0] KIND_TCP       = 3'd2;
    localparam logic [2:0] KIND_UDP       = 3'd3;
    localparam logic [2:0] KIND_MALFORMED = 3'd4;

    // one finished frame record, tdata order
    typedef struct packed {
        logic [15:0] flags_or_length;
        logic [31:0] ack_number;
        logic [31:0] seq_number;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [7:0]  ip_protocol;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [15:0] ether_type;
        logic [2:0]  frame_kind;
    } record_t;

    localparam int RecordBits = $bits(record_t);
    localparam int TdataBits  = ((RecordBits + 7) / 8) * 8;

endpackage

FILE: design/eipp_front.sv
// front end: byte position tracking, header field capture, record build on last byte
// depends on eipp_pkg
`timescale 1ns / 1ps

module eipp_front #(
    parameter int POSITION_WIDTH = eipp_pkg::PositionWidthDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    input  logic [7:0]          data_byte,
    input  logic                frame_last,
    output logic                rec_valid,
    output eipp_pkg::record_t   rec
);

    localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

    logic [POSITION_WIDTH-1:0] pos_reg;
    logic [5:0]  ihl_bytes_reg;
    logic [47:0] dmac_reg, smac_reg;
    logic [15:0] etype_reg;
    logic [7:0]  proto_reg;
    logic [31:0] sip_reg, dip_reg, ports_reg, seq_reg, ack_reg;
    logic [15:0] fl_reg;

    logic [47:0] dmac_next, smac_next;
    logic [15:0] etype_next, fl_next;
    logic [5:0]  ihl_next;
    logic [7:0]  proto_next;
    logic [31:0] sip_next, dip_next, ports_next, seq_next, ack_next;

    // position widened so compares against small constants never wrap
    logic [16:0] p;
    logic [16:0] n;
    logic [16:0] l4_start;
    logic [16:0] k;
    logic        ip_type;
    logic        l4_zone;
    eipp_pkg::record_t rec_c;

    assign p        = 17'(pos_reg);
    assign n        = p + 17'd1;
    assign ip_type  = (etype_next == eipp_pkg::ETHERTYPE_IPV4) && (p >= 17'd14);
    assign l4_start = 17'd14 + 17'(ihl_bytes_reg);
    assign k        = p - l4_start;
    assign l4_zone  = ip_type && (p != 17'd14) && (ihl_bytes_reg >= 6'd20)
                      && (p >= l4_start);

    always_comb begin
        dmac_next  = dmac_reg;
        smac_next  = smac_reg;
        etype_next = etype_reg;
        ihl_next   = ihl_bytes_reg;
        proto_next = proto_reg;
        sip_next   = sip_reg;
        dip_next   = dip_reg;
        ports_next = ports_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        fl_next    = fl_reg;
        // ethernet header
        if (p < 17'd6) begin
            dmac_next[8*(5-p[2:0]) +: 8] = data_byte;
        end else if (p < 17'd12) begin
            smac_next[8*(11-p[3:0]) +: 8] = data_byte;
        end else if (p < 17'd14) begin
            etype_next[8*(13-p[3:0]) +: 8] = data_byte;
        end
        // ipv4 header
        if (ip_type) begin
            if (p == 17'd14) begin
                ihl_next = {data_byte[3:0], 2'b00};
            end else if (p == 17'd23) begin
                proto_next = data_byte;
            end else if (p >= 17'd26 && p < 17'd30) begin
                sip_next[8*(29-p[4:0]) +: 8] = data_byte;
            end else if (p >= 17'd30 && p < 17'd34) begin
                dip_next[8*(33-p[5:0]) +: 8] = data_byte;
            end
        end
        // layer-4 header
        if (l4_zone) begin
            if (k < 17'd4) begin
                ports_next[8*(3-k[1:0]) +: 8] = data_byte;
            end else if (proto_reg == eipp_pkg::PROTO_TCP) begin
                if (k < 17'd8) begin
                    seq_next[8*(7-k[2:0]) +: 8] = data_byte;
                end else if (k < 17'd12) begin
                    ack_next[8*(11-k[3:0]) +: 8] = data_byte;
                end else if (k == 17'd13) begin
                    fl_next = {10'd0, data_byte[5:0]};
                end
            end else if (proto_reg == eipp_pkg::PROTO_UDP) begin
                if (k < 17'd6) begin
                    fl_next[8*(5-k[2:0]) +: 8] = data_byte;
                end
            end
        end
    end

    // classification of a finished frame
    always_comb begin
        logic ip_ok;
        logic l4_ok;
        ip_ok = 1'b0;
        l4_ok = 1'b0;
        rec_c = '0;
        if (n < 17'd14) begin
            rec_c.frame_kind = eipp_pkg::KIND_MALFORMED;
        end else if (etype_next != eipp_pkg::ETHERTYPE_IPV4) begin
            rec_c.frame_kind = eipp_pkg::KIND_NOT_IP;
        end else if (n < 17'd34 || ihl_next < 6'd20
                     || n < 17'd14 + 17'(ihl_next)) begin
            rec_c.frame_kind = eipp_pkg::KIND_MALFORMED;
        end else if (proto_next == eipp_pkg::PROTO_TCP) begin
            rec_c.frame_kind = (n >= 17'd34 + 17'(ihl_next)) ?
                               eipp_pkg::KIND_TCP : eipp_pkg::KIND_MALFORMED;
        end else if (proto_next == eipp_pkg::PROTO_UDP) begin
            rec_c.frame_kind = (n >= 17'd22 + 17'(ihl_next)) ?
                               eipp_pkg::KIND_UDP : eipp_pkg::KIND_MALFORMED;
        end else begin
            rec_c.frame_kind = eipp_pkg::KIND_IP_OTHER;
        end
        ip_ok = (rec_c.frame_kind == eipp_pkg::KIND_IP_OTHER)
                || (rec_c.frame_kind == eipp_pkg::KIND_TCP)
                || (rec_c.frame_kind == eipp_pkg::KIND_UDP);
        l4_ok = (rec_c.frame_kind == eipp_pkg::KIND_TCP)
                || (rec_c.frame_kind == eipp_pkg::KIND_UDP);
        rec_c.ether_type = etype_next;
        rec_c.dest_mac   = dmac_next;
        rec_c.source_mac = smac_next;
        if (ip_ok) begin
            rec_c.source_ip   = sip_next;
            rec_c.dest_ip     = dip_next;
            rec_c.ip_protocol = proto_next;
        end
        if (l4_ok) begin
            rec_c.source_port     = ports_next[31:16];
            rec_c.dest_port       = ports_next[15:0];
            rec_c.flags_or_length = fl_next;
            if (rec_c.frame_kind == eipp_pkg::KIND_TCP) begin
                rec_c.seq_number = seq_next;
                rec_c.ack_number = ack_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ihl_bytes_reg <= '0;
            dmac_reg      <= '0;
            smac_reg      <= '0;
            etype_reg     <= '0;
            proto_reg     <= '0;
            sip_reg       <= '0;
            dip_reg       <= '0;
            ports_reg     <= '0;
            seq_reg       <= '0;
            ack_reg       <= '0;
            fl_reg        <= '0;
            rec_valid     <= 1'b0;
        end else begin
            rec_valid <= byte_valid && frame_last;
            if (byte_valid) begin
                if (frame_last) begin
                    pos_reg       <= '0;
                    ihl_bytes_reg <= '0;
                    dmac_reg      <= '0;
                    smac_reg      <= '0;
                    etype_reg     <= '0;
                    proto_reg     <= '0;
                    sip_reg       <= '0;
                    dip_reg       <= '0;
                    ports_reg     <= '0;
                    seq_reg       <= '0;
                    ack_reg       <= '0;
                    fl_reg        <= '0;
                end else begin
                    if (pos_reg != PosMax) begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    ihl_bytes_reg <= ihl_next;
                    dmac_reg      <= dmac_next;
                    smac_reg      <= smac_next;
                    etype_reg     <= etype_next;
                    proto_reg     <= proto_next;
                    sip_reg       <= sip_next;
                    dip_reg       <= dip_next;
                    ports_reg     <= ports_next;
                    seq_reg       <= seq_next;
                    ack_reg       <= ack_next;
                    fl_reg        <= fl_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_valid && frame_last) begin
            rec <= rec_c;
        end
    end

endmodule

FILE: design/eipp_queue.sv
// small record queue between the parser front end and the output stage
// depends on eipp_pkg
`timescale 1ns / 1ps

module eipp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  eipp_pkg::record_t in_rec,
    output logic              has_room,
    output logic              out_valid,
    output eipp_pkg::record_t out_rec,
    input  logic              out_ready
);

    // four entries: covers a record already in flight from the front end plus slack
    eipp_pkg::record_t mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_rec   = mem[rd_reg];
    assign push      = in_valid;
    assign pop       = out_valid && out_ready;
    // keep one spare slot for a record already in flight from the front end
    assign has_room  = (cnt_reg < 3'd3);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

FILE: design/eth_ipv4_l4_header_parser.sv
// ethernet/ipv4/tcp-udp header parser: 1 byte per cycle in while s_tready is high, one record per frame out
// the record passes through the front end's output register and then the record queue before it appears on m_axis
// throughput: 1 byte per cycle while fewer than 3 records wait; s_tready drops when 3 or more records wait
// reset: aresetn synchronous active low, clears parse state and the record queue
// depends on eipp_pkg, eipp_front, eipp_queue
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser #(
    parameter int POSITION_WIDTH = eipp_pkg::PositionWidthDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    input  logic                           s_tlast,   // frame_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_kind, ether_type, dest_mac, source_mac, source_ip, dest_ip, ip_protocol,
    // source_port, dest_port, seq_number, ack_number, flags_or_length (low bit up)
    output logic [eipp_pkg::TdataBits-1:0] m_tdata
);

    logic              byte_ok;
    logic              rec_valid;
    eipp_pkg::record_t rec;
    eipp_pkg::record_t q_rec;
    logic              room;

    assign s_tready = room;
    assign byte_ok  = s_tvalid && s_tready;

    // front end: tracks byte position and captures header fields
    eipp_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(byte_ok),
        .data_byte (s_tdata),
        .frame_last(s_tlast),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // record queue decouples parsing from the downstream consumer
    eipp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rec_valid),
        .in_rec   (rec),
        .has_room (room),
        .out_valid(m_tvalid),
        .out_rec  (q_rec),
        .out_ready(m_tready)
    );

    assign m_tdata = eipp_pkg::TdataBits'(q_rec);

endmodule

FILE: verif/eth_ipv4_l4_header_parser_checker.sv
// record checker for the ethernet/ipv4/l4 header parser: watches both channels,
// predicts one record per frame and compares the whole record, padding bits included
// depends on eipp_pkg
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_checker #(
    parameter int POSITION_WIDTH = eipp_pkg::PositionWidthDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [eipp_pkg::TdataBits-1:0] m_tdata,
    output int                             fail_count,
    output int                             records_pending
);

    localparam int PosMax = (1 << POSITION_WIDTH) - 1;

    int          pos;
    int          hdr_bytes;
    logic [47:0] dmac, smac;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] sip, dip, ports, seqn, ackn;
    logic [15:0] fl_len;
    int          frame_len;

    eipp_pkg::record_t record_queue[$];

    task automatic clear_frame();
        pos = 0; hdr_bytes = 0; dmac = '0; smac = '0; etype = '0; proto = '0;
        sip = '0; dip = '0; ports = '0; seqn = '0; ackn = '0; fl_len = '0;
        frame_len = 0;
    endtask

    // capture one header byte at wire position p
    task automatic capture_byte(input int p, input logic [7:0] b);
        int k;
        if (p < 6) dmac[8*(5-p) +: 8] = b;
        else if (p < 12) smac[8*(11-p) +: 8] = b;
        else if (p < 14) etype[8*(13-p) +: 8] = b;
        if (etype != eipp_pkg::ETHERTYPE_IPV4 || p < 14) return;
        if (p == 14) hdr_bytes = int'(b[3:0]) * 4;
        else if (p == 23) proto = b;
        else if (p >= 26 && p < 30) sip[8*(29-p) +: 8] = b;
        else if (p >= 30 && p < 34) dip[8*(33-p) +: 8] = b;
        if (p == 14 || hdr_bytes < 20 || p < 14 + hdr_bytes) return;
        k = p - (14 + hdr_bytes);
        if (k < 4) ports[8*(3-k) +: 8] = b;
        else if (proto == eipp_pkg::PROTO_TCP) begin
            if (k < 8) seqn[8*(7-k) +: 8] = b;
            else if (k < 12) ackn[8*(11-k) +: 8] = b;
            else if (k == 13) fl_len = {10'd0, b[5:0]};
        end else if (proto == eipp_pkg::PROTO_UDP) begin
            if (k < 6) fl_len[8*(5-k) +: 8] = b;
        end
    endtask

    // build the expected record at the end of a frame
    function automatic eipp_pkg::record_t frame_record();
        eipp_pkg::record_t r;
        int      n, l4;
        logic    ip_ok, l4_ok;
        r = '0;
        n = frame_len;
        ip_ok = 1'b0;
        l4_ok = 1'b0;
        if (n < 14) r.frame_kind = eipp_pkg::KIND_MALFORMED;
        else if (etype != eipp_pkg::ETHERTYPE_IPV4) r.frame_kind = eipp_pkg::KIND_NOT_IP;
        else if (n < 34 || hdr_bytes < 20 || n < 14 + hdr_bytes)
            r.frame_kind = eipp_pkg::KIND_MALFORMED;
        else begin
            l4 = 14 + hdr_bytes;
            if (proto == eipp_pkg::PROTO_TCP)
                r.frame_kind = (n >= l4 + 20) ? eipp_pkg::KIND_TCP : eipp_pkg::KIND_MALFORMED;
            else if (proto == eipp_pkg::PROTO_UDP)
                r.frame_kind = (n >= l4 + 8) ? eipp_pkg::KIND_UDP : eipp_pkg::KIND_MALFORMED;
            else r.frame_kind = eipp_pkg::KIND_IP_OTHER;
            ip_ok = (r.frame_kind != eipp_pkg::KIND_MALFORMED);
            l4_ok = (r.frame_kind == eipp_pkg::KIND_TCP || r.frame_kind == eipp_pkg::KIND_UDP);
        end
        r.ether_type = etype;
        r.dest_mac = dmac;
        r.source_mac = smac;
        if (ip_ok) begin
            r.source_ip = sip; r.dest_ip = dip; r.ip_protocol = proto;
        end
        if (l4_ok) begin
            r.source_port = ports[31:16];
            r.dest_port = ports[15:0];
            if (r.frame_kind == eipp_pkg::KIND_TCP) begin
                r.seq_number = seqn; r.ack_number = ackn;
            end
            r.flags_or_length = fl_len;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        eipp_pkg::record_t got, want;
        if (!aresetn) begin
            clear_frame();
            record_queue.delete();
            fail_count <= 0;
            records_pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                capture_byte(pos, s_tdata);
                frame_len = frame_len + 1;
                if (pos < PosMax) pos = pos + 1;
                if (s_tlast) begin
                    record_queue.push_back(frame_record());
                    clear_frame();
                end
            end
            if (m_tvalid && m_tready) begin
                got = eipp_pkg::record_t'(m_tdata[eipp_pkg::RecordBits-1:0]);
                if (record_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected record %h", got);
                end else begin
                    want = record_queue.pop_front();
                    if (got !== want
                        || m_tdata[eipp_pkg::TdataBits-1:eipp_pkg::RecordBits] !== '0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("record mismatch: kind exp %0d got %0d\n  exp %h\n  got %h",
                                     want.frame_kind, got.frame_kind, want, got);
                    end
                end
            end
            records_pending <= record_queue.size();
        end
    end

endmodule

FILE: verif/eth_ipv4_l4_header_parser_tb.sv
// testbench top for the ethernet/ipv4/l4 header parser: builds frames byte by byte,
// drives the input stream with random gaps and stalls the record stream
// depends on eipp_pkg, eth_ipv4_l4_header_parser, eth_ipv4_l4_header_parser_checker
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_tb;

    localparam int CycleLimit     = 2_000_000;
    localparam int LongHoldCycles = 300;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;   // data_byte
    logic                           s_tlast = 1'b0; // frame_last
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [eipp_pkg::TdataBits-1:0] m_tdata;        // record_t fields, frame_kind lowest

    int  fail_count;
    int  records_pending;
    int  cycles = 0;
    int  items_sent = 0;
    bit  long_hold = 1'b0;    // receiver holds off for a counted stretch once set

    // bytes of the frame being built
    logic [7:0] frame_bytes[$];

    always #5 aclk = ~aclk;

    eth_ipv4_l4_header_parser u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    eth_ipv4_l4_header_parser_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .records_pending(records_pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall per record, or a long counted hold-off when asked
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk iff (m_tvalid && m_tready) || long_hold);
            end
        end
    end

    // send the queued frame, one byte per handshake, with random gaps unless burst is set
    task automatic send_frame(input bit burst);
        int gap;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            gap = burst ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_bytes[i];
            s_tlast  <= (i == frame_bytes.size() - 1);
            @(posedge aclk iff s_tready);
            items_sent++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    function automatic void push_bytes(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
    endfunction

    // build a frame: ethertype, ihl, protocol and total length chosen by caller
    function automatic void build_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                                        input logic [7:0] proto, input int len);
        frame_bytes.delete();
        push_bytes({$urandom, $urandom}, 6);
        push_bytes({$urandom, $urandom}, 6);
        push_bytes(64'(etype), 2);
        frame_bytes.push_back(ver_ihl);
        for (int i = 15; i < 23; i++) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(proto);
        for (int i = 24; i < len + 64; i++) frame_bytes.push_back(8'($urandom));
        while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    endfunction

    // random frame, mostly well-formed ipv4 with random content
    function automatic void random_frame();
        int          pick, ihl, l4, len;
        logic [7:0]  proto;
        logic [15:0] etype;
        pick = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
        l4 = 14 + ihl * 4;
        case ($urandom_range(0, 3))
            0: proto = eipp_pkg::PROTO_TCP;
            1: proto = eipp_pkg::PROTO_UDP;
            2: proto = 8'($urandom);
            default: proto = ($urandom_range(0, 1) != 0) ? eipp_pkg::PROTO_TCP
                                                          : eipp_pkg::PROTO_UDP;
        endcase
        etype = (pick < 80) ? eipp_pkg::ETHERTYPE_IPV4 : 16'($urandom);
        if (pick < 60) len = l4 + 20 + $urandom_range(0, 12);
        else len = $urandom_range(1, 80);
        build_frame(etype, {4'($urandom), 4'(ihl)}, proto, len);
    endfunction

    task automatic drain();
        @(posedge aclk iff records_pending == 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int lens[12];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: short ethernet, non-ip, ip other, truncations, bad ihl, full frames
        lens = '{1, 13, 14, 33, 34, 53, 54, 41, 42, 60, 74, 200};
        foreach (lens[i]) begin
            build_frame(eipp_pkg::ETHERTYPE_IPV4, 8'h45,
                        (i % 2 == 0) ? eipp_pkg::PROTO_TCP : eipp_pkg::PROTO_UDP, lens[i]);
            send_frame(1'b0);
        end
        build_frame(16'h86DD, 8'h45, eipp_pkg::PROTO_TCP, 60); send_frame(1'b0);
        build_frame(eipp_pkg::ETHERTYPE_IPV4, 8'h45, 8'd1, 40); send_frame(1'b0);
        build_frame(eipp_pkg::ETHERTYPE_IPV4, 8'h44, eipp_pkg::PROTO_TCP, 60); send_frame(1'b0);
        build_frame(eipp_pkg::ETHERTYPE_IPV4, 8'h4F, eipp_pkg::PROTO_TCP, 94); send_frame(1'b0);
        build_frame(eipp_pkg::ETHERTYPE_IPV4, 8'h4F, eipp_pkg::PROTO_UDP, 80); send_frame(1'b0);
        // all-ones and all-zeros content
        build_frame(eipp_pkg::ETHERTYPE_IPV4, 8'hFF, eipp_pkg::PROTO_TCP, 94);
        foreach (frame_bytes[i]) if (i != 12 && i != 13 && i != 23) frame_bytes[i] = 8'hFF;
        send_frame(1'b1);
        build_frame(16'h0000, 8'h00, 8'h00, 20);
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
        send_frame(1'b1);

        // sender pauses until every record is out
        drain();

        // receiver holds off while short frames back up the input
        long_hold = 1'b1;
        for (int i = 0; i < 8; i++) begin
            build_frame(16'h1234, 8'h45, eipp_pkg::PROTO_TCP, 14);
            send_frame(1'b1);
        end

        // random frames until about 2000 items in total
        while (items_sent < 2000) begin
            random_frame();
            send_frame($urandom_range(0, 4) == 0);
        end

        @(posedge aclk iff records_pending == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
